### src/lexc_pkg.sv
// ----------------------------------------------------------------------------
// lexc_pkg
// Shared types, keyword tables and class codes for the token classifier.
// ----------------------------------------------------------------------------
package lexc_pkg;

  localparam int CHAR_W   = 8;
  localparam int POS_W    = 3;
  localparam int KW_COUNT = 10;
  localparam int KW_SLOTS = 8;   // table padded to the full position range
  localparam int CLASS_W  = 4;

  localparam logic [POS_W-1:0] POS_MAX = 3'd7;

  typedef enum logic [CLASS_W-1:0] {
    TOK_PLUS   = 4'd0,
    TOK_MINUS  = 4'd1,
    TOK_EQUALS = 4'd2,
    TOK_PRINT  = 4'd3,
    TOK_INPUT  = 4'd4,
    TOK_VAR    = 4'd5,
    TOK_VAL    = 4'd6,
    TOK_SEMI   = 4'd7,
    TOK_LPAREN = 4'd8,
    TOK_RPAREN = 4'd9,
    TOK_INT    = 4'd10,
    TOK_FLOAT  = 4'd11,
    TOK_IDENT  = 4'd12,
    TOK_STRING = 4'd13,
    TOK_NONE   = 4'd14
  } token_class_t;

  typedef logic [CHAR_W-1:0] char_t;

  // One input transaction as held in the input register
  typedef struct packed {
    char_t char_code;
    logic  is_last;
  } lexc_item_t;

  // Running per-lexeme state
  typedef struct packed {
    logic [POS_W-1:0]    char_position;
    logic [KW_COUNT-1:0] keyword_match_flags;
    logic                all_digits_flag;
    logic [1:0]          dot_count;
    logic                all_ident_flag;
    logic                first_quote_flag;
  } lexc_state_t;

  localparam lexc_state_t STATE_RESET = '{
    char_position:       '0,
    keyword_match_flags: '1,
    all_digits_flag:     1'b1,
    dot_count:           2'd0,
    all_ident_flag:      1'b1,
    first_quote_flag:    1'b0
  };

  localparam char_t CH_DOT   = 8'h2E;
  localparam char_t CH_QUOTE = 8'h22;
  localparam char_t CH_UNDER = 8'h5F;

  typedef char_t kw_row_t [KW_SLOTS];

  localparam kw_row_t KW_TEXT [KW_COUNT] = '{
    '{8'h2B, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, // +
    '{8'h2D, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, // -
    '{8'h3D, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, // =
    '{8'h70, 8'h72, 8'h69, 8'h6E, 8'h74, 8'h00, 8'h00, 8'h00}, // print
    '{8'h69, 8'h6E, 8'h70, 8'h75, 8'h74, 8'h00, 8'h00, 8'h00}, // input
    '{8'h76, 8'h61, 8'h72, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, // var
    '{8'h76, 8'h61, 8'h6C, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, // val
    '{8'h3B, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, // ;
    '{8'h28, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, // (
    '{8'h29, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}  // )
  };

  // Keyword lengths, as the last valid position (length - 1)
  localparam logic [POS_W-1:0] KW_LAST_POS [KW_COUNT] = '{
    3'd0, 3'd0, 3'd0, 3'd4, 3'd4, 3'd2, 3'd2, 3'd0, 3'd0, 3'd0
  };

endpackage

### src/lexc_in_reg.sv
// ----------------------------------------------------------------------------
// lexc_in_reg
// Input register stage: captures one transaction and holds it until consumed.
// ----------------------------------------------------------------------------
module lexc_in_reg
  import lexc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  lexc_item_t in_item,
  output logic       s1_valid,
  output lexc_item_t s1_item,
  input  logic       s1_advance
);

  logic       valid_r, valid_nxt;
  lexc_item_t item_r;

  assign in_ready  = !valid_r || s1_advance;
  assign valid_nxt = in_ready ? in_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

  assign s1_valid = valid_r;
  assign s1_item  = item_r;

endmodule

### src/lexc_classify.sv
// ----------------------------------------------------------------------------
// lexc_classify
// Per-character flag update and final class selection.
// ----------------------------------------------------------------------------
module lexc_classify
  import lexc_pkg::*;
(
  input  lexc_state_t  cur,
  input  char_t        char_code,
  output lexc_state_t  upd,
  output token_class_t token_class
);

  logic                is_digit, is_dot, is_letter, is_ident;
  logic [KW_COUNT-1:0] kw_flags;

  assign is_digit  = (char_code >= 8'h30) && (char_code <= 8'h39);
  assign is_dot    = (char_code == CH_DOT);
  assign is_letter = ((char_code >= 8'h41) && (char_code <= 8'h5A)) ||
                     ((char_code >= 8'h61) && (char_code <= 8'h7A));
  assign is_ident  = is_digit || is_letter || (char_code == CH_UNDER);

  always_comb begin
    for (int k = 0; k < KW_COUNT; k++) begin
      kw_flags[k] = cur.keyword_match_flags[k] &&
                    (cur.char_position <= KW_LAST_POS[k]) &&
                    (char_code == KW_TEXT[k][cur.char_position]);
    end
  end

  always_comb begin
    upd.char_position       = (cur.char_position < POS_MAX) ?
                              cur.char_position + 3'd1 : POS_MAX;
    upd.keyword_match_flags = kw_flags;
    upd.all_digits_flag     = cur.all_digits_flag && (is_digit || is_dot);
    upd.dot_count           = (is_dot && cur.dot_count < 2'd2) ?
                              cur.dot_count + 2'd1 : cur.dot_count;
    upd.all_ident_flag      = cur.all_ident_flag && is_ident;
    upd.first_quote_flag    = (cur.char_position == '0) ?
                              (char_code == CH_QUOTE) : cur.first_quote_flag;
  end

  always_comb begin
    token_class = TOK_NONE;
    if (upd.all_digits_flag && upd.dot_count == 2'd0) begin
      token_class = TOK_INT;
    end else if (upd.all_digits_flag && upd.dot_count == 2'd1) begin
      token_class = TOK_FLOAT;
    end else if (upd.all_ident_flag) begin
      token_class = TOK_IDENT;
    end else if (upd.first_quote_flag && char_code == CH_QUOTE) begin
      token_class = TOK_STRING;
    end
    // Fixed lexemes win; walk downward so the lowest code takes priority
    for (int k = KW_COUNT - 1; k >= 0; k--) begin
      if (kw_flags[k] && cur.char_position == KW_LAST_POS[k]) begin
        token_class = token_class_t'(k[CLASS_W-1:0]);
      end
    end
  end

endmodule

### src/lexeme_token_classifier_unit.sv
// ----------------------------------------------------------------------------
// lexeme_token_classifier_unit
// Lexeme classifier: one character per transaction, one class per lexeme.
// ----------------------------------------------------------------------------
// A lexeme's last character goes into the input register; its class and
// out_valid are registered once the result slot is free. Throughput: one
// character per cycle, set by the single flag-update pass between the input
// and result registers, while no last character waits on a full result slot.
// Reset (rst_n low, synchronous): both pipeline registers empty, lexeme
// state back to position 0, all keyword flags set, digit/ident flags set.
// ----------------------------------------------------------------------------
module lexeme_token_classifier_unit
  import lexc_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [CHAR_W-1:0]   in_char_code,
  input  logic                in_is_last,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [CLASS_W-1:0]  out_token_class
);

  // Input stage
  lexc_item_t   in_item;
  lexc_item_t   s1_item;
  logic         s1_valid;
  logic         s1_advance;

  // Lexeme state and classifier outputs
  lexc_state_t  state_r, state_nxt;
  lexc_state_t  state_upd;
  token_class_t class_comb;

  // Result register
  logic         out_valid_r, out_valid_nxt;
  token_class_t out_class_r;
  logic         out_free;
  logic         s1_fire;

  assign in_item.char_code = in_char_code;
  assign in_item.is_last   = in_is_last;

  lexc_in_reg u_in_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .s1_valid  (s1_valid),
    .s1_item   (s1_item),
    .s1_advance(s1_advance)
  );

  lexc_classify u_classify (
    .cur        (state_r),
    .char_code  (s1_item.char_code),
    .upd        (state_upd),
    .token_class(class_comb)
  );

  // The result slot is free when empty or being drained this cycle.
  assign out_free = !out_valid_r || out_ready;

  // A non-final character never needs the result slot, so it always moves on.
  assign s1_advance = !s1_item.is_last || out_free;
  assign s1_fire    = s1_valid && s1_advance;

  // A lexeme's last character returns all running state to reset values.
  always_comb begin
    state_nxt = state_r;
    if (s1_fire) begin
      state_nxt = s1_item.is_last ? STATE_RESET : state_upd;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    if (s1_fire && s1_item.is_last) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= STATE_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_item.is_last) begin
      out_class_r <= class_comb;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_token_class = out_class_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------

  // Finishing a lexeme leaves the state at its reset values.
  a_state_clears: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && s1_item.is_last |=> state_r == STATE_RESET)
    else $error("lexeme state not cleared after last character");

  // The dot count saturates at two.
  a_dot_sat: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.dot_count != 2'd3)
    else $error("dot count overflow");

  // Past the longest fixed lexeme no keyword can still be matching.
  a_kw_dead: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.char_position > 3'd5 |-> state_r.keyword_match_flags == '0)
    else $error("keyword flag alive beyond longest keyword");

  // A new result only appears after a final character left the input stage.
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_fire && s1_item.is_last))
    else $error("result without a final character");

endmodule

### sim/tb_lexeme_token_classifier_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_lexeme_token_classifier_unit
// Streams lexemes one character per transaction into the classifier and
// checks every class code against a cycle-free model of the running flags.
// ----------------------------------------------------------------------------
module tb_lexeme_token_classifier_unit;
  import lexc_pkg::*;

  localparam int CLK_HALF           = 4;
  localparam int RESET_CYCLES       = 3;
  localparam int RESULT_HOLD_CYCLES = 300;   // long receiver back-pressure stretch
  localparam int QUIET_LIMIT        = 3000;  // cycles with no transaction on either side
  localparam int DRAIN_CYCLES       = 10;    // margin after the drain for any stray result

  // --------------------------------------------------------------------------
  // Expected-class tracker: mirrors the per-lexeme flags and queues one class
  // per completed lexeme, in order.
  // --------------------------------------------------------------------------
  class lexeme_scoreboard;
    string        kw_text [KW_COUNT];
    logic [2:0]   pos;
    logic [9:0]   kw_live;
    bit           all_dig;
    logic [1:0]   dots;
    bit           all_id;
    bit           quote_first;
    token_class_t pending [$];
    int           errors;
    int           checked;
    int           class_seen [16];

    function new();
      kw_text = '{"+", "-", "=", "print", "input", "var", "val", ";", "(", ")"};
      errors  = 0;
      checked = 0;
      foreach (class_seen[i]) class_seen[i] = 0;
      clear_state();
    endfunction

    function void clear_state();
      pos         = '0;
      kw_live     = '1;
      all_dig     = 1'b1;
      dots        = 2'd0;
      all_id      = 1'b1;
      quote_first = 1'b0;
    endfunction

    // One accepted input transaction
    function void note_char(logic [7:0] c, logic last);
      logic [9:0]   hit;
      bit           is_dig;
      bit           is_dot;
      bit           is_id;
      bit           dig_all;
      bit           id_all;
      bit           quote;
      logic [1:0]   nd;
      token_class_t cls;
      is_dig = (c >= 8'h30) && (c <= 8'h39);
      is_dot = (c == CH_DOT);
      is_id  = is_dig || (c == CH_UNDER) ||
               ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
      hit = '0;
      for (int k = 0; k < KW_COUNT; k++) begin
        if (kw_live[k] && (pos < kw_text[k].len()) && (c == kw_text[k][pos]))
          hit[k] = 1'b1;
      end
      dig_all = all_dig && (is_dig || is_dot);
      nd = dots;
      if (is_dot && (nd < 2'd2)) nd = nd + 2'd1;
      id_all = all_id && is_id;
      quote  = (pos == 3'd0) ? (c == CH_QUOTE) : quote_first;

      if (!last) begin
        kw_live     = hit;
        all_dig     = dig_all;
        dots        = nd;
        all_id      = id_all;
        quote_first = quote;
        if (pos != POS_MAX) pos = pos + 3'd1;
        return;
      end

      // Fixed lexemes win; lowest code first when several could match
      cls = TOK_NONE;
      for (int k = KW_COUNT - 1; k >= 0; k--) begin
        if (hit[k] && (pos + 1 == kw_text[k].len())) cls = token_class_t'(k);
      end
      if (cls == TOK_NONE) begin
        if (dig_all && (nd == 2'd0))      cls = TOK_INT;
        else if (dig_all && (nd == 2'd1)) cls = TOK_FLOAT;
        else if (id_all)                  cls = TOK_IDENT;
        else if (quote && (c == CH_QUOTE)) cls = TOK_STRING;
      end
      pending.push_back(cls);
      clear_state();
    endfunction

    // One accepted result transaction
    function void check_class(logic [3:0] got);
      token_class_t want;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: token_class unexpected, expected none, actual %0d", $time, got);
        return;
      end
      want = pending.pop_front();
      checked++;
      class_seen[want]++;
      if (got !== want) begin
        errors++;
        $display("%0t: token_class mismatch, expected %0d (%s), actual %0d",
                 $time, want, want.name(), got);
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // DUT hookup; every input known from time zero
  // --------------------------------------------------------------------------
  logic               clk          = 1'b0;
  logic               rst_n        = 1'b0;
  logic               in_valid     = 1'b0;
  logic               in_ready;
  logic [CHAR_W-1:0]  in_char_code = '0;
  logic               in_is_last   = 1'b0;
  logic               out_valid;
  logic               out_ready    = 1'b0;
  logic [CLASS_W-1:0] out_token_class;

  lexeme_token_classifier_unit u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_char_code    (in_char_code),
    .in_is_last      (in_is_last),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_token_class (out_token_class)
  );

  always #CLK_HALF clk = ~clk;

  lexeme_scoreboard sb = new();

  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  bit          hold_results  = 1'b0;
  int          chars_sent    = 0;
  int          quiet_cycles  = 0;
  logic [7:0]  lex_buf [$];

  // --------------------------------------------------------------------------
  // Result side: random back-pressure, plus one long hold when requested.
  // All samples are taken right at the edge, before any NBA of that step lands.
  // --------------------------------------------------------------------------
  initial begin
    forever begin
      @(posedge clk);
      if (hold_results) begin
        out_ready <= 1'b0;
        repeat (RESULT_HOLD_CYCLES) @(posedge clk);
        hold_results = 1'b0;
      end
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_class(out_token_class);
  end

  // Watchdog: a stuck handshake on either side ends the run
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
      $display("tb_lexeme_token_classifier_unit: done, errors");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Character side
  // --------------------------------------------------------------------------
  task automatic send_char(logic [7:0] c, logic last);
    // random gaps before the transaction; valid then holds until accepted
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_char_code <= c;
    in_is_last   <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_char(c, last);
    chars_sent++;
  endtask

  task automatic send_lexeme();
    for (int i = 0; i < lex_buf.size(); i++) send_char(lex_buf[i], i == lex_buf.size() - 1);
  endtask

  task automatic send_text(string s);
    lex_buf.delete();
    for (int i = 0; i < s.len(); i++) lex_buf.push_back(s[i]);
    send_lexeme();
  endtask

  // Sender pause: drop valid and sit until every queued class has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] ident_char();
    int r;
    r = $urandom_range(0, 62);
    if (r < 10)      return 8'(8'h30 + r);
    else if (r < 36) return 8'(8'h41 + (r - 10));
    else if (r < 62) return 8'(8'h61 + (r - 36));
    else             return CH_UNDER;
  endfunction

  // Mostly well-formed lexemes of every class, some near misses, some noise.
  // Lengths stay short; now and then long enough to saturate the position.
  function automatic void build_random_lexeme();
    string mix;
    int    kind;
    int    n;
    int    k;
    mix  = "0123456789.+-e";
    kind = $urandom_range(0, 99);
    n    = ($urandom_range(0, 15) == 0) ? $urandom_range(6, 12) : $urandom_range(1, 5);
    lex_buf.delete();
    if (kind < 15) begin
      // fixed lexeme, sometimes clipped, extended or with one char changed
      k = $urandom_range(0, KW_COUNT - 1);
      for (int i = 0; i < sb.kw_text[k].len(); i++) lex_buf.push_back(sb.kw_text[k][i]);
      case ($urandom_range(0, 3))
        0: if (lex_buf.size() > 1) void'(lex_buf.pop_back());
        1: lex_buf.push_back(8'($urandom_range(8'h21, 8'h7E)));
        2: lex_buf[$urandom_range(0, lex_buf.size() - 1)] = ident_char();
        default: ;
      endcase
    end else if (kind < 30) begin
      repeat (n) lex_buf.push_back(8'(8'h30 + $urandom_range(0, 9)));
    end else if (kind < 45) begin
      repeat (n) lex_buf.push_back(8'(8'h30 + $urandom_range(0, 9)));
      lex_buf.insert($urandom_range(0, n), CH_DOT);
      if ($urandom_range(0, 4) == 0) lex_buf.insert($urandom_range(0, n + 1), CH_DOT);
    end else if (kind < 65) begin
      repeat (n) lex_buf.push_back(ident_char());
    end else if (kind < 80) begin
      // quoted text; a lone quote and a missing closing quote both occur
      lex_buf.push_back(CH_QUOTE);
      repeat (n - 1) lex_buf.push_back(8'($urandom_range(8'h20, 8'h7E)));
      if ($urandom_range(0, 3) != 0) lex_buf.push_back(CH_QUOTE);
    end else if (kind < 90) begin
      repeat (n) lex_buf.push_back(8'($urandom_range(0, 255)));
    end else begin
      repeat (n) lex_buf.push_back(mix[$urandom_range(0, mix.len() - 1)]);
    end
  endfunction

  task automatic run_random(int upto);
    while (chars_sent < upto) begin
      build_random_lexeme();
      send_lexeme();
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 34;
    recv_idle_pct = 48;

    // Directed: every fixed lexeme, lone dot, lone quote, byte extremes
    foreach (sb.kw_text[k]) send_text(sb.kw_text[k]);
    send_text(".");
    send_text("\"");
    lex_buf = '{8'h00};
    send_lexeme();
    lex_buf = '{8'hFF};
    send_lexeme();
    wait_drained();

    // Long result stall while characters keep coming: input must back up
    hold_results = 1'b1;
    repeat (40) begin
      build_random_lexeme();
      send_lexeme();
    end

    run_random(540);
    wait_drained();

    send_idle_pct = 48;
    recv_idle_pct = 34;
    run_random(1060);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(1575);

    // Drain, then keep the clock running to show any stray result
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.pending.size() != 0) begin
      sb.errors++;
      $display("%0t: %0d expected classes never arrived", $time, sb.pending.size());
    end

    $display("run covered %0d characters in %0d lexemes under three idle mixes and a long stall",
             chars_sent, sb.checked);
    $display("classes: ops/keywords %0d, int %0d, float %0d, ident %0d, string %0d, none %0d",
             sb.checked - sb.class_seen[TOK_INT] - sb.class_seen[TOK_FLOAT]
             - sb.class_seen[TOK_IDENT] - sb.class_seen[TOK_STRING] - sb.class_seen[TOK_NONE],
             sb.class_seen[TOK_INT], sb.class_seen[TOK_FLOAT], sb.class_seen[TOK_IDENT],
             sb.class_seen[TOK_STRING], sb.class_seen[TOK_NONE]);
    if (sb.errors == 0) begin
      $display("tb_lexeme_token_classifier_unit: done, clean");
    end else begin
      $display("tb_lexeme_token_classifier_unit: done, errors");
    end
    $finish;
  end

endmodule
